FILE: rtl/core/abrf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abrf_pkg: shared types and constants
// Request/response structs, operation codes, mode classes and controller states.
// ----------------------------------------------------------------------------
package abrf_pkg;

   typedef enum logic [3:0] {
      OP_RD = 4'd0, OP_WR = 4'd1, OP_RD_USR = 4'd2, OP_WR_USR = 4'd3,
      OP_RD_CPSR = 4'd4, OP_WR_CPSR = 4'd5, OP_RD_SPSR = 4'd6, OP_WR_SPSR = 4'd7,
      OP_JUMP = 4'd8, OP_SWI = 4'd9, OP_UND = 4'd10, OP_IRQ = 4'd11,
      OP_COND = 4'd12, OP_RESET = 4'd13, OP_NOP14 = 4'd14, OP_NOP15 = 4'd15
   } op_type;

   typedef enum logic [2:0] {
      CL_USR = 3'd0, CL_FIQ = 3'd1, CL_IRQ = 3'd2, CL_SVC = 3'd3,
      CL_ABT = 3'd4, CL_UND = 3'd5, CL_NONE = 3'd6
   } class_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0, ST_EXEC = 2'd1, ST_RESP = 2'd2
   } state_type;

   typedef struct packed {
      logic [3:0]  operation;
      logic [3:0]  reg_index;
      logic [31:0] write_value;
      logic [3:0]  cond_code;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        cond_true;
      logic        flush;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic exec;
   } cmd_type;

   localparam logic [31:0] MASK_HALF = 32'hffff_fffe;
   localparam logic [31:0] MASK_WORD = 32'hffff_fffc;
   localparam logic [4:0]  MODE_SVC  = 5'h13;
   localparam logic [4:0]  MODE_IRQ  = 5'h12;
   localparam logic [4:0]  MODE_UND  = 5'h1b;
   localparam logic [4:0]  MODE_SYS  = 5'h1f;
   localparam logic [31:0] VEC_UND   = 32'h0000_0004;
   localparam logic [31:0] VEC_SWI   = 32'h0000_0008;
   localparam logic [31:0] VEC_IRQ   = 32'h0000_0018;
   localparam logic [31:0] BOOT_SP   = 32'h0300_7f00;
   localparam logic [31:0] BOOT_PC   = 32'h0800_0000;
   localparam logic [31:0] BOOT_SP_IRQ = 32'h0300_7fa0;
   localparam logic [31:0] BOOT_SP_SVC = 32'h0300_7fe0;

   function automatic class_type mode_class(input logic [4:0] m);
      class_type c;
      unique case (m)
         5'h00, 5'h10, 5'h1f: c = CL_USR;
         5'h01, 5'h11:        c = CL_FIQ;
         5'h02, 5'h12:        c = CL_IRQ;
         5'h03, 5'h13:        c = CL_SVC;
         5'h17:               c = CL_ABT;
         5'h1b:               c = CL_UND;
         default:             c = CL_NONE;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/abrf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abrf_ctrl: request sequencer
// Loads a request, runs it through the datapath, holds the response.
// ----------------------------------------------------------------------------
module abrf_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output abrf_pkg::cmd_type     cmd
);
   import abrf_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

FILE: rtl/core/abrf_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abrf_dp: register file datapath
// Active registers, banks, status word and the response register.
// ----------------------------------------------------------------------------
module abrf_dp (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire abrf_pkg::cmd_type cmd,
   input  wire abrf_pkg::req_type req_data,
   output abrf_pkg::rsp_type      rsp_data
);
   import abrf_pkg::*;

   req_type     req_ff;
   rsp_type     rsp_ff, rsp_in;
   logic [31:0] act_ff [16], act_in [16];
   logic [31:0] usr_ff [7],  usr_in [7];
   logic [31:0] fiq_ff [7],  fiq_in [7];
   logic [31:0] prv_ff [8],  prv_in [8];
   logic [31:0] sps_ff [5],  sps_in [5];
   logic [6:0]  flg_ff, flg_in;
   logic [4:0]  mode_ff, mode_in;

   class_type   cls;
   logic [31:0] cpsr;
   logic [3:0]  r;
   logic [31:0] v;
   logic        n, z, c, vf;

   always_comb begin
      cls  = mode_class(mode_ff);
      cpsr = {flg_ff[6:3], 20'd0, flg_ff[2:0], mode_ff};
      r    = req_ff.reg_index;
      v    = req_ff.write_value;
      n    = flg_ff[6];
      z    = flg_ff[5];
      c    = flg_ff[4];
      vf   = flg_ff[3];
   end

   always_comb begin
      class_type   oc, nc;
      logic [4:0]  nm;
      logic        chg, usr_bank_hit, expt;
      logic [31:0] old_cpsr, vec;
      logic [2:0]  ui;
      act_in  = act_ff;
      usr_in  = usr_ff;
      fiq_in  = fiq_ff;
      prv_in  = prv_ff;
      sps_in  = sps_ff;
      flg_in  = flg_ff;
      mode_in = mode_ff;
      rsp_in  = '0;
      chg     = 1'b0;
      expt    = 1'b0;
      nm      = mode_ff;
      vec     = VEC_SWI;
      old_cpsr = cpsr;
      oc = cls;
      nc = cls;
      usr_bank_hit = !(cls == CL_USR || r <= 4'd7 || r == 4'd15
                       || (cls != CL_FIQ && r <= 4'd12));
      ui = 3'(r - 4'd8);
      unique case (op_type'(req_ff.operation))
         OP_RD: rsp_in.read_data = act_ff[r];
         OP_WR, OP_WR_USR: begin
            if (r == 4'd15) begin
               act_in[15] = v & (flg_ff[0] ? MASK_HALF : MASK_WORD);
               rsp_in.flush = 1'b1;
            end else if (req_ff.operation == OP_WR_USR && usr_bank_hit) usr_in[ui] = v;
            else act_in[r] = v;
         end
         OP_RD_USR: rsp_in.read_data = usr_bank_hit ? usr_ff[ui] : act_ff[r];
         OP_RD_CPSR: rsp_in.read_data = cpsr;
         OP_WR_CPSR: begin
            flg_in = {v[31:28], v[7:5]};
            nm = v[4:0]; chg = 1'b1;
         end
         OP_RD_SPSR: begin
            if (cls == CL_USR) rsp_in.read_data = cpsr;
            else if (cls != CL_NONE) rsp_in.read_data = sps_ff[3'(cls - CL_FIQ)];
         end
         OP_WR_SPSR: begin
            if (cls == CL_USR) begin
               flg_in = {v[31:28], v[7:5]};
               nm = v[4:0]; chg = 1'b1;
            end else if (cls != CL_NONE) sps_in[3'(cls - CL_FIQ)] = v;
         end
         OP_JUMP: begin
            act_in[15] = v & (flg_ff[0] ? MASK_HALF : MASK_WORD);
            rsp_in.flush = 1'b1;
         end
         OP_SWI: begin nm = MODE_SVC; vec = VEC_SWI; chg = 1'b1; expt = 1'b1; end
         OP_UND: begin nm = MODE_UND; vec = VEC_UND; chg = 1'b1; expt = 1'b1; end
         OP_IRQ: begin nm = MODE_IRQ; vec = VEC_IRQ; chg = 1'b1; expt = 1'b1; end
         OP_COND: begin
            unique case (req_ff.cond_code)
               4'd0:  rsp_in.cond_true = z;
               4'd1:  rsp_in.cond_true = !z;
               4'd2:  rsp_in.cond_true = c;
               4'd3:  rsp_in.cond_true = !c;
               4'd4:  rsp_in.cond_true = n;
               4'd5:  rsp_in.cond_true = !n;
               4'd6:  rsp_in.cond_true = vf;
               4'd7:  rsp_in.cond_true = !vf;
               4'd8:  rsp_in.cond_true = c && !z;
               4'd9:  rsp_in.cond_true = !c || z;
               4'd10: rsp_in.cond_true = n == vf;
               4'd11: rsp_in.cond_true = n != vf;
               4'd12: rsp_in.cond_true = !z && (n == vf);
               4'd13: rsp_in.cond_true = z || (n != vf);
               4'd14: rsp_in.cond_true = 1'b1;
               default: rsp_in.cond_true = 1'b0;
            endcase
         end
         OP_RESET: begin
            rsp_in.flush = 1'b1;
            for (int i = 0; i < 16; i++) act_in[i] = '0;
            for (int i = 0; i < 7; i++) begin usr_in[i] = '0; fiq_in[i] = '0; end
            for (int i = 0; i < 8; i++) prv_in[i] = '0;
            for (int i = 0; i < 5; i++) sps_in[i] = '0;
            flg_in = '0;
            if (v[0]) begin
               act_in[13] = BOOT_SP;
               act_in[15] = BOOT_PC;
               prv_in[0]  = BOOT_SP_IRQ;
               prv_in[2]  = BOOT_SP_SVC;
               mode_in    = MODE_SYS;
            end else mode_in = MODE_SVC;
         end
         default: ;
      endcase

      if (chg) begin
         nc = mode_class(nm);
         if (oc == CL_USR) begin
            for (int i = 0; i < 7; i++) usr_in[i] = act_ff[8 + i];
         end else if (oc == CL_FIQ) begin
            for (int i = 0; i < 7; i++) fiq_in[i] = act_ff[8 + i];
         end else if (oc != CL_NONE) begin
            for (int i = 0; i < 5; i++) usr_in[i] = act_ff[8 + i];
            prv_in[{2'(oc - CL_IRQ), 1'b0}] = act_ff[13];
            prv_in[{2'(oc - CL_IRQ), 1'b1}] = act_ff[14];
         end
         if (nc == CL_USR) begin
            for (int i = 0; i < 7; i++) act_in[8 + i] = usr_in[i];
         end else if (nc == CL_FIQ) begin
            for (int i = 0; i < 7; i++) act_in[8 + i] = fiq_in[i];
         end else if (nc != CL_NONE) begin
            for (int i = 0; i < 5; i++) act_in[8 + i] = usr_in[i];
            act_in[13] = prv_in[{2'(nc - CL_IRQ), 1'b0}];
            act_in[14] = prv_in[{2'(nc - CL_IRQ), 1'b1}];
         end
         mode_in = nm;
         if (expt) begin
            sps_in[3'(nc - CL_FIQ)] = old_cpsr;
            act_in[14]   = act_ff[15];
            flg_in[0]    = 1'b0;
            flg_in[2]    = 1'b1;
            act_in[15]   = vec & MASK_WORD;
            rsp_in.flush = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_data;
      if (cmd.exec) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) act_ff[i] <= '0;
         for (int i = 0; i < 7; i++) begin usr_ff[i] <= '0; fiq_ff[i] <= '0; end
         for (int i = 0; i < 8; i++) prv_ff[i] <= '0;
         for (int i = 0; i < 5; i++) sps_ff[i] <= '0;
         flg_ff  <= '0;
         mode_ff <= MODE_SVC;
      end else if (cmd.exec) begin
         act_ff  <= act_in;
         usr_ff  <= usr_in;
         fiq_ff  <= fiq_in;
         prv_ff  <= prv_in;
         sps_ff  <= sps_in;
         flg_ff  <= flg_in;
         mode_ff <= mode_in;
      end
   end

   assign rsp_data = rsp_ff;
endmodule
`default_nettype wire

FILE: rtl/core/arm_banked_register_file.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arm_banked_register_file: ARMv4T banked registers and status word
// Usage:
//   req_* carries one operation (register, CPSR/SPSR access, jump,
//   exception entry, condition test or soft reset) as a req_type struct.
//   rsp_* returns one rsp_type response per request: read data, condition
//   result and a flush flag when R15 was redirected.
//   A request is taken when req_valid is high and req_stall low; the same
//   for the response with rsp_valid and rsp_stall.
//   After a request is taken the controller passes its execute state and
//   then its respond state, where rsp_valid rises and the response waits.
//   No new request is taken until that response has been taken, as set by
//   the load / execute / respond sequence of the controller.
//   A mode change copies R8-R14 between the active set and the banks in the
//   execute cycle.
//   Reset: state cleared, mode supervisor; no request pending.
//   While rsp_stall is high the response holds and req_stall stays high.
// ----------------------------------------------------------------------------
module arm_banked_register_file (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire abrf_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output abrf_pkg::rsp_type      rsp_data
);
   import abrf_pkg::*;

   cmd_type cmd;

   abrf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   abrf_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("request taken while response pending");
   a_exec_then_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> rsp_valid) else $error("execute not followed by response");
   a_load_then_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.exec) else $error("load not followed by execute");
endmodule
`default_nettype wire

FILE: tb/arm_banked_register_file_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm_banked_register_file_checker: response predictor and scoreboard
// Watches the request and response channels, predicts each response from a
// private copy of the register banks and status word, and counts mismatches.
// ----------------------------------------------------------------------------
module arm_banked_register_file_checker
   import abrf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_stall,
   input  wire req_type req_data,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_stall,
   input  wire rsp_type rsp_data,
   output int           fail_count,
   output int           pending_count
);

   logic [31:0] regs [16];
   logic [31:0] usr_bank [7];
   logic [31:0] fiq_bank [7];
   logic [31:0] priv_bank [8];
   logic [31:0] spsr [5];
   logic        fn, fz, fc, fv, fi, ff, ft;
   logic [4:0]  mode;
   rsp_type     expected_rsps [$];

   function automatic class_type classify(logic [4:0] m);
      case (m)
         5'h00, 5'h10, 5'h1f: return CL_USR;
         5'h01, 5'h11:        return CL_FIQ;
         5'h02, 5'h12:        return CL_IRQ;
         5'h03, 5'h13:        return CL_SVC;
         5'h17:               return CL_ABT;
         5'h1b:               return CL_UND;
         default:             return CL_NONE;
      endcase
   endfunction

   function automatic logic [31:0] cpsr_word();
      return {fn, fz, fc, fv, 20'd0, fi, ff, ft, mode};
   endfunction

   task automatic clear_all(input logic skip);
      for (int i = 0; i < 16; i++) regs[i] = '0;
      for (int i = 0; i < 7; i++) begin
         usr_bank[i] = '0;
         fiq_bank[i] = '0;
      end
      for (int i = 0; i < 8; i++) priv_bank[i] = '0;
      for (int i = 0; i < 5; i++) spsr[i] = '0;
      {fn, fz, fc, fv, fi, ff, ft} = '0;
      if (skip) begin
         regs[13] = BOOT_SP;
         regs[15] = BOOT_PC;
         priv_bank[0] = BOOT_SP_IRQ;
         priv_bank[2] = BOOT_SP_SVC;
         mode = MODE_SYS;
      end else begin
         mode = MODE_SVC;
      end
   endtask

   task automatic switch_mode(input logic [4:0] nm);
      class_type oc, nc;
      oc = classify(mode);
      nc = classify(nm);
      if (oc == CL_USR) begin
         for (int i = 0; i < 7; i++) usr_bank[i] = regs[8+i];
      end else if (oc == CL_FIQ) begin
         for (int i = 0; i < 7; i++) fiq_bank[i] = regs[8+i];
      end else if (oc != CL_NONE) begin
         for (int i = 0; i < 5; i++) usr_bank[i] = regs[8+i];
         priv_bank[(oc-CL_IRQ)*2]   = regs[13];
         priv_bank[(oc-CL_IRQ)*2+1] = regs[14];
      end
      if (nc == CL_USR) begin
         for (int i = 0; i < 7; i++) regs[8+i] = usr_bank[i];
      end else if (nc == CL_FIQ) begin
         for (int i = 0; i < 7; i++) regs[8+i] = fiq_bank[i];
      end else if (nc != CL_NONE) begin
         for (int i = 0; i < 5; i++) regs[8+i] = usr_bank[i];
         regs[13] = priv_bank[(nc-CL_IRQ)*2];
         regs[14] = priv_bank[(nc-CL_IRQ)*2+1];
      end
      mode = nm;
   endtask

   task automatic load_cpsr(input logic [31:0] v);
      {fn, fz, fc, fv} = v[31:28];
      {fi, ff, ft} = v[7:5];
      switch_mode(v[4:0]);
   endtask

   task automatic branch(input logic [31:0] a);
      regs[15] = a & (ft ? MASK_HALF : MASK_WORD);
   endtask

   task automatic enter_exception(input logic [4:0] nm, input logic [31:0] vec);
      logic [31:0] old;
      old = cpsr_word();
      switch_mode(nm);
      spsr[classify(nm) - CL_FIQ] = old;
      regs[14] = regs[15];
      ft = 1'b0;
      fi = 1'b1;
      branch(vec);
   endtask

   function automatic logic cond_met(logic [3:0] c);
      case (c)
         4'd0:  return fz;
         4'd1:  return !fz;
         4'd2:  return fc;
         4'd3:  return !fc;
         4'd4:  return fn;
         4'd5:  return !fn;
         4'd6:  return fv;
         4'd7:  return !fv;
         4'd8:  return fc && !fz;
         4'd9:  return !fc || fz;
         4'd10: return fn == fv;
         4'd11: return fn != fv;
         4'd12: return !fz && (fn == fv);
         4'd13: return fz || (fn != fv);
         4'd14: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   // user-bank access: 1 when it lands in the user bank rather than regs
   function automatic logic hits_user_bank(logic [3:0] r);
      class_type c;
      c = classify(mode);
      return !(c == CL_USR || r <= 7 || r == 15 || (c != CL_FIQ && r <= 12));
   endfunction

   function automatic int user_slot(logic [3:0] r);
      return (int'(r) - 8) % 7;
   endfunction

   task automatic predict(input req_type q);
      rsp_type   e;
      class_type c;
      e = '0;
      c = classify(mode);
      case (op_type'(q.operation))
         OP_RD: e.read_data = regs[q.reg_index];
         OP_WR: begin
            if (q.reg_index == 4'd15) begin
               branch(q.write_value);
               e.flush = 1'b1;
            end else regs[q.reg_index] = q.write_value;
         end
         OP_RD_USR: e.read_data = hits_user_bank(q.reg_index) ?
            usr_bank[user_slot(q.reg_index)] : regs[q.reg_index];
         OP_WR_USR: begin
            if (q.reg_index == 4'd15) begin
               branch(q.write_value);
               e.flush = 1'b1;
            end else if (hits_user_bank(q.reg_index))
               usr_bank[user_slot(q.reg_index)] = q.write_value;
            else regs[q.reg_index] = q.write_value;
         end
         OP_RD_CPSR: e.read_data = cpsr_word();
         OP_WR_CPSR: load_cpsr(q.write_value);
         OP_RD_SPSR: begin
            if (c == CL_USR) e.read_data = cpsr_word();
            else if (c != CL_NONE) e.read_data = spsr[c - CL_FIQ];
         end
         OP_WR_SPSR: begin
            if (c == CL_USR) load_cpsr(q.write_value);
            else if (c != CL_NONE) spsr[c - CL_FIQ] = q.write_value;
         end
         OP_JUMP: begin
            branch(q.write_value);
            e.flush = 1'b1;
         end
         OP_SWI: begin
            enter_exception(MODE_SVC, VEC_SWI);
            e.flush = 1'b1;
         end
         OP_UND: begin
            enter_exception(MODE_UND, VEC_UND);
            e.flush = 1'b1;
         end
         OP_IRQ: begin
            enter_exception(MODE_IRQ, VEC_IRQ);
            e.flush = 1'b1;
         end
         OP_COND: e.cond_true = cond_met(q.cond_code);
         OP_RESET: begin
            clear_all(q.write_value[0]);
            e.flush = 1'b1;
         end
         default: ;
      endcase
      expected_rsps.push_back(e);
   endtask

   always_ff @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         clear_all(1'b0);
         expected_rsps.delete();
         fail_count <= 0;
         pending_count <= 0;
      end else begin
         if (req_valid && !req_stall) predict(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               if (fail_count < 10)
                  $display("ERROR: unexpected response %h", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_rsps.pop_front();
               if (e !== rsp_data) begin
                  if (fail_count < 10)
                     $display("ERROR: rsp mismatch exp rd=%h ct=%b fl=%b got rd=%h ct=%b fl=%b",
                        e.read_data, e.cond_true, e.flush,
                        rsp_data.read_data, rsp_data.cond_true, rsp_data.flush);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_count <= expected_rsps.size();
      end
   end

endmodule

FILE: tb/arm_banked_register_file_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm_banked_register_file_tb: request stimulus and verdict
// Drives directed and random register, status, jump, exception, condition
// and reset requests with random idling and stalls; a checker scores results.
// ----------------------------------------------------------------------------
module arm_banked_register_file_tb;
   import abrf_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_count;
   logic    hold_rsp = 1'b0;
   logic    quiet = 1'b0;
   logic    done = 1'b0;

   localparam logic [4:0] MODES [10] = '{5'h10, 5'h11, 5'h12, 5'h13, 5'h17,
                                        5'h1b, 5'h1f, 5'h00, 5'h03, 5'h05};

   always #5 clock = ~clock;

   arm_banked_register_file DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   arm_banked_register_file_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always @(negedge clock) begin
      if (hold_rsp) rsp_stall <= 1'b1;
      else if (quiet) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < 9);
   end

   task automatic send(input op_type op, input logic [3:0] r,
                       input logic [31:0] v, input logic [3:0] cc);
      if (!quiet) begin
         while ($urandom_range(99) < 9) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data <= '{operation: op, reg_index: r, write_value: v, cond_code: cc};
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_random();
      int k;
      logic [31:0] v;
      k = $urandom_range(99);
      v = $urandom;
      if (k < 12) send(OP_WR_CPSR, 4'd0, {v[31:5], MODES[$urandom_range(9)]}, 4'd0);
      else if (k < 14) send(OP_WR_CPSR, 4'd0, v, 4'd0);
      else if (k < 15) send(OP_RESET, 4'd0, v, 4'd0);
      else send(op_type'(4'($urandom_range(15))), 4'($urandom_range(15)), v,
                4'($urandom_range(15)));
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send(OP_RD_CPSR, 0, 0, 0);
      send(OP_WR, 4'd0, 32'hffff_ffff, 0);
      send(OP_RD, 4'd0, 0, 0);
      send(OP_WR, 4'd15, 32'hffff_ffff, 0);
      send(OP_RD, 4'd15, 0, 0);
      send(OP_WR_CPSR, 0, 32'hf000_00f1, 0);
      send(OP_WR, 4'd14, 32'h1234_5678, 0);
      send(OP_RD_USR, 4'd14, 0, 0);
      send(OP_WR_USR, 4'd9, 32'haaaa_5555, 0);
      send(OP_WR_USR, 4'd15, 32'h0000_0003, 0);
      send(OP_WR_SPSR, 0, 32'h8000_0010, 0);
      send(OP_RD_SPSR, 0, 0, 0);
      send(OP_COND, 0, 0, 4'd12);
      send(OP_SWI, 0, 0, 0);
      send(OP_UND, 0, 0, 0);
      send(OP_IRQ, 0, 0, 0);
      send(OP_RD, 4'd14, 0, 0);
      send(OP_WR_CPSR, 0, 32'h0000_0005, 0);
      send(OP_RD_SPSR, 0, 0, 0);
      send(OP_WR_SPSR, 0, 32'hffff_ffff, 0);
      send(OP_WR_CPSR, 0, 32'h0000_001f, 0);
      send(OP_RD_SPSR, 0, 0, 0);
      send(OP_RESET, 0, 32'h1, 0);
      send(OP_RD, 4'd13, 0, 0);
      send(OP_NOP15, 4'hf, 32'hffff_ffff, 4'hf);
      send(OP_RESET, 0, 32'h0, 0);
      quiet <= 1'b1;
      for (int i = 0; i < 80; i++) send_random();
      quiet <= 1'b0;
      hold_rsp <= 1'b1;
      for (int i = 0; i < 20; i++) send_random();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      for (int i = 0; i < 300; i++) send_random();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      done <= 1'b1;
   end

   // receiver hold-off, timed independently
   initial begin
      wait (hold_rsp);
      repeat (60) @(negedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      wait (done);
      @(posedge clock);
      if (fail_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
